// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of this block.
// No dependencies; take it in with an include of the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/core/med5_pkg.sv =====
// Types and fixed widths for the five-sample median filter.
// No dependencies; the front end, back end, top level, checker and testbench import it.
package med5_pkg;

	localparam int TIME_BITS   = 32;
	localparam int SAMPLE_BITS = 32;

	// One input transfer: a timestamped Q16.16 sample.
	typedef struct packed {
		logic                          series_start;
		logic [TIME_BITS-1:0]          sample_time;
		logic signed [SAMPLE_BITS-1:0] sample_value;
	} in_item_t;

	// One output transfer: median value tagged with the middle timestamp.
	typedef struct packed {
		logic [TIME_BITS-1:0]          median_time;
		logic signed [SAMPLE_BITS-1:0] median_value;
	} out_item_t;

endpackage

// ===== rtl/core/med5_queue.sv =====
// Small register queue that decouples the window front end from the sort back end.
// Depends on nothing but its parameters.
module med5_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push_fire;
	logic             pop_fire;

	// Handshake status follows the fill count only.
	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_data   = slot_q[rd_ptr_q];
	assign push_fire  = push_valid && push_ready;
	assign pop_fire   = pop_valid && pop_ready;

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push_fire) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop_fire) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push_fire && !pop_fire) begin
				count_q <= count_q + 1'b1;
			end else if (pop_fire && !push_fire) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage carries payload only and needs no reset.
	always_ff @(posedge clk) begin
		if (push_fire) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/med5_front.sv =====
// Front end: accepts samples, keeps the sliding window and the fill count,
// and forwards every full window. Depends on med5_pkg.
module med5_front #(
	parameter int WINDOW     = 5,
	parameter int VALUE_BITS = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            in_valid,
	output logic                                            in_ready,
	input  med5_pkg::in_item_t                              in_data,
	output logic                                            win_valid,
	input  logic                                            win_ready,
	output logic [WINDOW*VALUE_BITS+med5_pkg::TIME_BITS-1:0] win_data
);

	import med5_pkg::*;

	localparam int CNT_W = $clog2(WINDOW + 1);
	localparam int MID   = WINDOW / 2;

	// Only the newest WINDOW-1 samples are kept; the incoming one completes the window.
	logic signed [VALUE_BITS-1:0] values_q [1:WINDOW-1];
	logic [TIME_BITS-1:0]         times_q  [MID+1:WINDOW-1];
	logic [CNT_W-1:0]             fill_q;
	logic [CNT_W-1:0]             count_base;
	logic [CNT_W-1:0]             fill_next;
	logic signed [VALUE_BITS-1:0] raw_value;
	logic                         accept;

	// Bring the Q16.16 input to the datapath width.
	if (VALUE_BITS <= SAMPLE_BITS) begin : g_trunc
		assign raw_value = in_data.sample_value[VALUE_BITS-1:0];
	end else begin : g_sext
		assign raw_value = {{(VALUE_BITS - SAMPLE_BITS){in_data.sample_value[SAMPLE_BITS-1]}},
			in_data.sample_value};
	end

	// A start flag restarts the count; the count saturates at the window size.
	always_comb begin
		count_base = in_data.series_start ? '0 : fill_q;
		fill_next  = (count_base == CNT_W'(WINDOW)) ? count_base : count_base + 1'b1;
	end

	// Only the samples that complete a window produce a queue transfer.
	assign in_ready  = win_ready;
	assign win_valid = in_valid && (fill_next == CNT_W'(WINDOW));
	assign accept    = in_valid && in_ready;

	// Window after the shift, oldest value lowest, middle timestamp on top.
	always_comb begin
		win_data = '0;
		for (int k = 0; k < WINDOW - 1; k++) begin
			win_data[k*VALUE_BITS +: VALUE_BITS] = values_q[k+1];
		end
		win_data[(WINDOW-1)*VALUE_BITS +: VALUE_BITS] = raw_value;
		win_data[WINDOW*VALUE_BITS +: TIME_BITS]      = times_q[MID+1];
	end

	// Fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= fill_next;
		end
	end

	// Window shift; entries are only read once the count says they are valid.
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 1; k < WINDOW - 1; k++) begin
				values_q[k] <= values_q[k+1];
			end
			values_q[WINDOW-1] <= raw_value;
			for (int k = MID + 1; k < WINDOW - 1; k++) begin
				times_q[k] <= times_q[k+1];
			end
			times_q[WINDOW-1] <= in_data.sample_time;
		end
	end

endmodule

// ===== rtl/core/med5_back.sv =====
// Back end: two-stage rank network that picks the median of a full window.
// Stage 1 registers the pairwise compares, stage 2 ranks and selects. Depends on med5_pkg.
module med5_back #(
	parameter int WINDOW     = 5,
	parameter int VALUE_BITS = 32
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            win_valid,
	output logic                                            win_ready,
	input  logic [WINDOW*VALUE_BITS+med5_pkg::TIME_BITS-1:0] win_data,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output med5_pkg::out_item_t                             out_data
);

	import med5_pkg::*;

	localparam int MID    = WINDOW / 2;
	localparam int RANK_W = $clog2(WINDOW);

	logic signed [VALUE_BITS-1:0] val_in  [WINDOW];
	logic [WINDOW-1:0]            le_c    [WINDOW];
	logic                         valid_s1;
	logic [WINDOW-1:0]            le_s1   [WINDOW];
	logic signed [VALUE_BITS-1:0] val_s1  [WINDOW];
	logic [TIME_BITS-1:0]         time_s1;
	logic                         valid_s2;
	out_item_t                    med_s2;
	logic                         ready_s2;
	logic [RANK_W-1:0]            rank_c  [WINDOW];
	logic [WINDOW-1:0]            match_c;
	logic [VALUE_BITS-1:0]        median_c;
	logic [SAMPLE_BITS-1:0]       median_out;

	// Stage enables: each stage loads when its successor can take its content.
	assign ready_s2  = !valid_s2 || out_ready;
	assign win_ready = !valid_s1 || ready_s2;

	// Unpack the window and compare every earlier sample against every later one.
	// le_c[i][j] for j < i says sample j sorts before sample i (ties keep arrival order).
	always_comb begin
		for (int k = 0; k < WINDOW; k++) begin
			val_in[k] = win_data[k*VALUE_BITS +: VALUE_BITS];
		end
		for (int i = 0; i < WINDOW; i++) begin
			le_c[i] = '0;
			for (int j = 0; j < i; j++) begin
				le_c[i][j] = (val_in[j] <= val_in[i]);
			end
		end
	end

	// Stage 1 valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (win_ready) begin
			valid_s1 <= win_valid;
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (win_valid && win_ready) begin
			le_s1   <= le_c;
			val_s1  <= val_in;
			time_s1 <= win_data[WINDOW*VALUE_BITS +: TIME_BITS];
		end
	end

	// Rank of each sample in the stable sort; exactly one sample has the middle rank.
	always_comb begin
		median_c = '0;
		for (int i = 0; i < WINDOW; i++) begin
			rank_c[i] = '0;
			for (int j = 0; j < WINDOW; j++) begin
				if (j < i) begin
					rank_c[i] = rank_c[i] + RANK_W'(le_s1[i][j]);
				end else if (j > i) begin
					rank_c[i] = rank_c[i] + RANK_W'(!le_s1[j][i]);
				end
			end
			match_c[i] = (rank_c[i] == RANK_W'(MID));
			median_c   = median_c | (val_s1[i] & {VALUE_BITS{match_c[i]}});
		end
	end

	// Return the median to the 32-bit output format.
	if (VALUE_BITS >= SAMPLE_BITS) begin : g_out_trunc
		assign median_out = median_c[SAMPLE_BITS-1:0];
	end else begin : g_out_sext
		assign median_out = {{(SAMPLE_BITS - VALUE_BITS){median_c[VALUE_BITS-1]}}, median_c};
	end

	// Stage 2 valid, which is also the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage 2 payload, held while the output transfer is stalled.
	always_ff @(posedge clk) begin
		if (valid_s1 && ready_s2) begin
			med_s2.median_time  <= time_s1;
			med_s2.median_value <= median_out;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = med_s2;

endmodule

// ===== rtl/core/median_of_five_filter.sv =====
// Sliding-window median filter (default window five) with timestamp tag.
// Throughput: one sample per cycle unless the output stalls; one result per window.
// Path: a full window is written into the queue, then passes the two back-end stages
// (compare, then rank and select) before its result is offered.
// Reset (arst_n low, asynchronous) empties the window, the queue and the pipeline.
module median_of_five_filter #(
	parameter int WINDOW     = 5,
	parameter int VALUE_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  med5_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output med5_pkg::out_item_t out_data
);

	import med5_pkg::*;

	localparam int ENTRY_W     = WINDOW * VALUE_BITS + TIME_BITS;
	localparam int QUEUE_DEPTH = 2;

	logic               win_valid;
	logic               win_ready;
	logic [ENTRY_W-1:0] win_data;
	logic               job_valid;
	logic               job_ready;
	logic [ENTRY_W-1:0] job_data;

	// Window keeping and classification of each sample.
	med5_front #(
		.WINDOW     (WINDOW),
		.VALUE_BITS (VALUE_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.win_valid (win_valid),
		.win_ready (win_ready),
		.win_data  (win_data)
	);

	// Full windows waiting for the sort network.
	med5_queue #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (win_valid),
		.push_ready (win_ready),
		.push_data  (win_data),
		.pop_valid  (job_valid),
		.pop_ready  (job_ready),
		.pop_data   (job_data)
	);

	// Median selection and output register.
	med5_back #(
		.WINDOW     (WINDOW),
		.VALUE_BITS (VALUE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (job_valid),
		.win_ready (job_ready),
		.win_data  (job_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== rtl/core/med5_checker.sv =====
// Port-level checker for the median filter, bound to the top level below.
// Depends on med5_pkg and assert_macros.svh.
`include "assert_macros.svh"

module med5_checker #(
	parameter int WINDOW = 5
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input med5_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input med5_pkg::out_item_t out_data
);

	import med5_pkg::*;

	localparam int SEEN_W   = $clog2(WINDOW + 1);
	localparam int OWED_W   = 4;
	localparam int PIPE_CAP = 4;

	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_base;
	logic [SEEN_W-1:0] seen_next;
	logic [OWED_W-1:0] owed_q;
	logic              in_fire;
	logic              out_fire;
	logic              completes;

	// Track how many results the accepted samples call for.
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign seen_base = in_data.series_start ? '0 : seen_q;
	assign seen_next = (seen_base == SEEN_W'(WINDOW)) ? seen_base : seen_base + 1'b1;
	assign completes = (seen_next == SEEN_W'(WINDOW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
			owed_q <= '0;
		end else begin
			if (in_fire) begin
				seen_q <= seen_next;
			end
			if ((in_fire && completes) && !out_fire) begin
				owed_q <= owed_q + 1'b1;
			end else if (out_fire && !(in_fire && completes)) begin
				owed_q <= owed_q - 1'b1;
			end
		end
	end

	// A stalled result stays offered and unchanged.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data))

	// No result appears without a completed window behind it.
	`ASSERT_IMPL(a_no_spurious, clk, arst_n, out_valid, owed_q != '0)

	// The queue and the two stages bound the results in flight.
	`ASSERT_IMPL(a_owed_cap, clk, arst_n, 1'b1, owed_q <= OWED_W'(PIPE_CAP))

	// Input backpressure only arises behind an offered result.
	`ASSERT_IMPL(a_backpressure, clk, arst_n, !in_ready, out_valid)

endmodule

bind median_of_five_filter med5_checker #(.WINDOW(WINDOW)) u_med5_checker (.*);

// ===== verif/median_of_five_filter_tb.sv =====
// Self-checking testbench for median_of_five_filter: directed and random sample series.
// Depends on med5_pkg and the median_of_five_filter RTL. It predicts each median
// from its own copy of the five-sample window.
module median_of_five_filter_tb;
	import med5_pkg::*;

	localparam int WINDOW   = 5;
	localparam int MID      = WINDOW / 2;
	localparam int MAX_IDLE = 14;
	localparam int RANDOM_SAMPLES = 1800;
	localparam int TIMEOUT  = 20_000_000;

	// Value patterns for random series.
	typedef enum int {
		VAL_ANY,
		VAL_NARROW,
		VAL_EXTREME,
		VAL_MIXED
	} value_mode_e;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_item_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	// Expected window contents, oldest first, and the medians still owed.
	logic signed [SAMPLE_BITS-1:0] win_val [WINDOW];
	logic [TIME_BITS-1:0]          win_time [WINDOW];
	int                            win_fill;
	out_item_t                     pending_medians [$];

	int  samples_sent;
	int  medians_checked;
	int  mismatches;
	bit  burst_mode;

	median_of_five_filter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// Clock with a 20 unit period.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Shift one accepted sample into the window and queue its median once full.
	function automatic void slide_window(input in_item_t s);
		logic signed [SAMPLE_BITS-1:0] sorted [WINDOW];
		logic signed [SAMPLE_BITS-1:0] v;
		out_item_t med;
		int j;
		if (s.series_start) begin
			for (int i = 0; i < WINDOW; i++) begin
				win_val[i] = '0;
				win_time[i] = '0;
			end
			win_fill = 0;
		end
		for (int i = 0; i + 1 < WINDOW; i++) begin
			win_val[i] = win_val[i + 1];
			win_time[i] = win_time[i + 1];
		end
		win_val[WINDOW - 1] = s.sample_value;
		win_time[WINDOW - 1] = s.sample_time;
		if (win_fill < WINDOW)
			win_fill++;
		if (win_fill == WINDOW) begin
			// Stable insertion sort on signed values.
			for (int i = 0; i < WINDOW; i++) begin
				v = win_val[i];
				j = i;
				while (j > 0 && sorted[j - 1] > v) begin
					sorted[j] = sorted[j - 1];
					j--;
				end
				sorted[j] = v;
			end
			med.median_time = win_time[MID];
			med.median_value = sorted[MID];
			pending_medians.push_back(med);
		end
	endfunction

	// Send one sample after a random gap, none in burst mode; returns after its transfer.
	task automatic send_sample(input bit start, input logic [TIME_BITS-1:0] t,
			input logic signed [SAMPLE_BITS-1:0] v);
		in_item_t item;
		int gap;
		item.series_start = start;
		item.sample_time = t;
		item.sample_value = v;
		gap = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (!in_ready);
		slide_window(item);
		samples_sent++;
	endtask

	// Result side: random stalls outside burst mode, then each transfer is checked against the oldest expectation.
	initial begin
		out_item_t want;
		int stall;
		wait (arst_n);
		forever begin
			stall = burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do
				@(posedge clk);
			while (!out_valid);
			if (pending_medians.size() == 0) begin
				$error("unexpected median: time %0d value %0d",
					out_data.median_time, out_data.median_value);
				mismatches++;
			end else begin
				want = pending_medians.pop_front();
				medians_checked++;
				if (out_data.median_time !== want.median_time) begin
					$error("median_time: expected %0d, got %0d",
						want.median_time, out_data.median_time);
					mismatches++;
				end
				if (out_data.median_value !== want.median_value) begin
					$error("median_value: expected %0d, got %0d",
						want.median_value, out_data.median_value);
					mismatches++;
				end
			end
		end
	end

	// A first series right after reset, without a start flag, with extreme
	// values and timestamps that jump back and forth.
	task automatic test_unflagged_start();
		send_sample(1'b0, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
		send_sample(1'b0, 32'h8000_0000, 32'sh8000_0000);
		send_sample(1'b0, 32'h0000_0001, 32'sh0000_0000);
		send_sample(1'b0, 32'h0000_0000, -32'sd1);
		send_sample(1'b0, 32'h7FFF_FFFF, 32'sd1);
		send_sample(1'b0, 32'h0000_1234, 32'sh8000_0000);
		send_sample(1'b0, 32'hDEAD_BEEF, 32'sh7FFF_FFFF);
	endtask

	// Equal values, alone and mixed with others.
	task automatic test_equal_values();
		for (int i = 0; i < 5; i++)
			send_sample(i == 0, 32'd100 + i, 32'sh0001_8000);
		send_sample(1'b0, 32'd105, -32'sh0001_8000);
		send_sample(1'b0, 32'd106, -32'sh0001_8000);
	endtask

	// A short series cut off by a new one, which must start from an empty window.
	task automatic test_series_restart();
		for (int i = 0; i < 3; i++)
			send_sample(i == 0, 32'd500 + i, 32'sd1000 * (i + 1));
		for (int i = 0; i < 6; i++)
			send_sample(i == 0, 32'd900 - i, -32'sd77 * (i % 3));
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_value(input value_mode_e mode);
		logic signed [SAMPLE_BITS-1:0] v;
		v = $urandom();
		case (mode)
			VAL_NARROW: begin
				v = $signed($urandom_range(0, 8)) - 4;
			end
			VAL_EXTREME: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7FFF_FFFF;
					2: v = '0;
					3: v = -32'sd1;
					default: v = 32'sd1;
				endcase
			end
			VAL_MIXED: begin
				if ($urandom_range(0, 1))
					v = pick_value(VAL_NARROW);
			end
			default: begin
			end
		endcase
		return v;
	endfunction

	// Random series: mostly full ones, some too short to give a median,
	// some that carry on without a start flag.
	task automatic test_random_series();
		value_mode_e mode;
		logic [TIME_BITS-1:0] t;
		int len;
		bit step_time;
		bit flagged;
		int target;
		target = samples_sent + RANDOM_SAMPLES;
		while (samples_sent < target) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
			mode = value_mode_e'($urandom_range(0, 3));
			step_time = $urandom_range(0, 3) != 0;
			flagged = $urandom_range(0, 9) != 0;
			burst_mode = $urandom_range(0, 3) == 0;
			t = $urandom();
			for (int k = 0; k < len; k++) begin
				send_sample(flagged && k == 0, t, pick_value(mode));
				t = step_time ? t + 1 : $urandom();
			end
		end
		burst_mode = 1'b0;
	endtask

	// Main sequence.
	initial begin
		for (int i = 0; i < WINDOW; i++) begin
			win_val[i] = '0;
			win_time[i] = '0;
		end
		win_fill = 0;
		samples_sent = 0;
		medians_checked = 0;
		mismatches = 0;
		burst_mode = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_unflagged_start();
		test_equal_values();
		test_series_restart();
		test_random_series();

		// Drop valid at the edge of the last transfer so it is not taken twice.
		in_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Sent %0d samples in directed and random series; %0d medians compared.",
			samples_sent, medians_checked);
		if (mismatches == 0 && pending_medians.size() == 0) begin
			$display("** median_of_five_filter: PASSED **");
		end else begin
			$display("** median_of_five_filter: FAILED **");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#(TIMEOUT);
		$display("** median_of_five_filter: FAILED **");
		$finish;
	end

endmodule
